// File: rtl/windowed_gust_and_average_macros.svh
// Assertion macros for the windowed gust and average block.
// Included by files that carry concurrent assertions; needs no package.
`ifndef WINDOWED_GUST_AND_AVERAGE_MACROS_SVH
`define WINDOWED_GUST_AND_AVERAGE_MACROS_SVH

`ifndef ASSERT_OFF
// Assertion on an explicit clock and active-low reset.
`define WGAA_ASSERT_CLK(label, clock, rstn, prop, msg) \
	label: assert property (@(posedge clock) disable iff (!rstn) prop) else $error(msg);
// Assertion on the block clock clk and reset arst_n.
`define WGAA_ASSERT(label, prop, msg) \
	`WGAA_ASSERT_CLK(label, clk, arst_n, prop, msg)
`else
`define WGAA_ASSERT_CLK(label, clock, rstn, prop, msg)
`define WGAA_ASSERT(label, prop, msg)
`endif

`endif

// File: rtl/wgaa_pkg.sv
// Shared constants, register indexes and controller/datapath structs
// for the windowed gust and average block. No dependencies.
package wgaa_pkg;

	localparam int DEPTH      = 256;
	localparam int ADDR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W      = $clog2(DEPTH + 1);
	localparam int SPEED_W    = 16;
	localparam int STAMP_W    = 32;
	localparam int WIN_W      = 16;
	localparam int SUM_W      = SPEED_W + CNT_W;
	localparam int ENTRY_W    = SPEED_W + STAMP_W;
	localparam int STEP_W     = $clog2(SPEED_W + 1);
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 16;

	localparam logic [ADDR_W-1:0] LAST_SLOT = ADDR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0]  FULL_COUNT = CNT_W'(DEPTH);

	localparam logic [CFG_IDX_W-1:0] REG_AVG_WINDOW  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_GUST_WINDOW = CFG_IDX_W'(1);

	localparam logic [WIN_W-1:0] AVG_WINDOW_RESET  = WIN_W'(60);
	localparam logic [WIN_W-1:0] GUST_WINDOW_RESET = WIN_W'(5);

	localparam logic CMD_SAMPLE = 1'b0;
	localparam logic CMD_TICK   = 1'b1;

	typedef struct packed {
		logic accept;
		logic issue;
		logic div_start;
		logic out_load;
	} wgaa_cmd_t;

	typedef struct packed {
		logic walk_done;
		logic rd_pend;
		logic div_busy;
		logic out_full;
	} wgaa_stat_t;

endpackage

// File: rtl/wgaa_if.sv
// Valid/ready channel interfaces: input items, results and register writes.
// Depends on wgaa_pkg for field widths.
interface wgaa_sample_if import wgaa_pkg::*; ();
	logic               valid;
	logic               ready;
	logic               command;
	logic [SPEED_W-1:0] speed;

	modport source (output valid, output command, output speed, input ready);
	modport sink (input valid, input command, input speed, output ready);
endinterface

interface wgaa_result_if import wgaa_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [SPEED_W-1:0] gust_speed;
	logic [SPEED_W-1:0] average_speed;

	modport source (output valid, output gust_speed, output average_speed, input ready);
	modport sink (input valid, input gust_speed, input average_speed, output ready);
endinterface

interface wgaa_cfg_if import wgaa_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// File: rtl/windowed_gust_and_average.sv
// Windowed gust and average: one result per input item, one item at a time.
// The walk reads at most 256 stored samples, one store entry per cycle, and
// stops early at the first sample outside both windows; then a restoring
// divider forms the mean. The result waits in an output register, so the
// next item is taken before it is collected. Reset clears the walk, fill
// and seconds counters and the pointers at once and sets the windows to
// their reset values; the store is not cleared.
`include "windowed_gust_and_average_macros.svh"

module windowed_gust_and_average import wgaa_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	wgaa_sample_if.sink   sample,
	wgaa_result_if.source result,
	wgaa_cfg_if.sink      cfg
);

	wgaa_cmd_t  cmd;
	wgaa_stat_t stat;
	logic       in_ready;

	wgaa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (sample.valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	wgaa_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.in_command    (sample.command),
		.in_speed      (sample.speed),
		.cfg_valid     (cfg.valid),
		.cfg_index     (cfg.index),
		.cfg_data      (cfg.data),
		.out_ready     (result.ready),
		.out_valid     (result.valid),
		.gust_speed    (result.gust_speed),
		.average_speed (result.average_speed)
	);

	assign sample.ready = in_ready;
	assign cfg.ready    = 1'b1;

	`WGAA_ASSERT(a_accept_leaves_idle, (sample.valid && sample.ready) |=> !sample.ready, "item taken while busy")
	`WGAA_ASSERT(a_load_when_free, cmd.out_load |-> !stat.out_full, "result register overwritten")
	`WGAA_ASSERT(a_div_after_walk, cmd.div_start |-> (stat.walk_done && !stat.rd_pend), "divide before walk end")
	`WGAA_ASSERT(a_div_runs, cmd.div_start |=> stat.div_busy, "divider did not start")

endmodule

// File: rtl/wgaa_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module wgaa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: rtl/wgaa_div.sv
// Restoring divider for the mean: one quotient bit per cycle.
// Depends on wgaa_pkg. The quotient is known to fit in SPEED_W bits.
module wgaa_div import wgaa_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [SUM_W-1:0]   dividend,
	input  logic [CNT_W-1:0]   divisor,
	output logic               busy,
	output logic [SPEED_W-1:0] quotient
);

	logic [CNT_W-1:0]   rem_q;
	logic [SPEED_W-1:0] low_q;
	logic [STEP_W-1:0]  step_q;
	logic               busy_q;
	logic [CNT_W:0]     partial;
	logic               ge;
	logic [CNT_W:0]     diff;

	// Starting from the top bits is safe because the mean never exceeds the
	// largest sample, so those bits are already below the divisor.
	assign partial = {rem_q, low_q[SPEED_W-1]};
	assign ge      = partial >= {1'b0, divisor};
	assign diff    = partial - {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			step_q <= STEP_W'(SPEED_W);
		end else if (busy_q) begin
			step_q <= step_q - 1'b1;
			if (step_q == STEP_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend[SUM_W-1:SPEED_W];
			low_q <= dividend[SPEED_W-1:0];
		end else if (busy_q) begin
			rem_q <= ge ? diff[CNT_W-1:0] : partial[CNT_W-1:0];
			low_q <= {low_q[SPEED_W-2:0], ge};
		end
	end

	assign busy     = busy_q;
	assign quotient = low_q;

endmodule

// File: rtl/wgaa_ctrl.sv
// Controller: sequences accept, store walk, division and result hand-off.
// Depends on wgaa_pkg for the command and status structs.
module wgaa_ctrl import wgaa_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  wgaa_stat_t stat,
	output wgaa_cmd_t  cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_WALK,
		S_DIV,
		S_WAIT_DIV,
		S_FINISH
	} state_t;

	state_t state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_WALK;
					end
				end
				S_WALK: begin
					// The last read still has to be evaluated before the sums are final.
					if (stat.walk_done && !stat.rd_pend) begin
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					state_q <= S_WAIT_DIV;
				end
				S_WAIT_DIV: begin
					if (!stat.div_busy) begin
						state_q <= S_FINISH;
					end
				end
				S_FINISH: begin
					if (!stat.out_full) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_comb begin
		in_ready      = state_q == S_IDLE;
		cmd.accept    = (state_q == S_IDLE) && in_valid;
		cmd.issue     = (state_q == S_WALK) && !stat.walk_done;
		cmd.div_start = state_q == S_DIV;
		cmd.out_load  = (state_q == S_FINISH) && !stat.out_full;
	end

endmodule

// File: rtl/wgaa_dp.sv
// Datapath: window registers, seconds counter, sample store, walk
// accumulators, divider and output register. Depends on wgaa_pkg,
// wgaa_ram and wgaa_div.
module wgaa_dp import wgaa_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  wgaa_cmd_t             cmd,
	output wgaa_stat_t            stat,
	input  logic                  in_command,
	input  logic [SPEED_W-1:0]    in_speed,
	input  logic                  cfg_valid,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  out_ready,
	output logic                  out_valid,
	output logic [SPEED_W-1:0]    gust_speed,
	output logic [SPEED_W-1:0]    average_speed
);

	logic [WIN_W-1:0]   avg_win_q;
	logic [WIN_W-1:0]   gust_win_q;
	logic [ADDR_W-1:0]  wp_q;
	logic [ADDR_W-1:0]  slot_q;
	logic [ADDR_W-1:0]  wp_next;
	logic [ADDR_W-1:0]  prev_slot;
	logic [CNT_W-1:0]   fill_q;
	logic [CNT_W-1:0]   n_q;
	logic [CNT_W-1:0]   count_q;
	logic [STAMP_W-1:0] now_q;
	logic               gust_open_q;
	logic               avg_open_q;
	logic               rd_s1;
	logic [SPEED_W-1:0] gust_q;
	logic [SUM_W-1:0]   sum_q;
	logic [ENTRY_W-1:0] rd_data;
	logic [SPEED_W-1:0] rd_speed;
	logic [STAMP_W-1:0] rd_stamp;
	logic [STAMP_W-1:0] age;
	logic               gust_old;
	logic               avg_old;
	logic               ram_we;
	logic [SPEED_W-1:0] quotient;
	logic               div_busy;
	logic               out_valid_q;
	logic [SPEED_W-1:0] out_gust_q;
	logic [SPEED_W-1:0] out_avg_q;

	assign wp_next   = (wp_q == LAST_SLOT) ? '0 : wp_q + 1'b1;
	assign prev_slot = (slot_q == '0) ? LAST_SLOT : slot_q - 1'b1;
	assign ram_we    = cmd.accept && (in_command == CMD_SAMPLE);

	wgaa_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (wp_q),
		.wdata ({in_speed, now_q}),
		.re    (cmd.issue),
		.raddr (prev_slot),
		.rdata (rd_data)
	);

	assign rd_speed = rd_data[ENTRY_W-1:STAMP_W];
	assign rd_stamp = rd_data[STAMP_W-1:0];
	// Age is taken modulo 2^32, so a wrapped counter still ages samples correctly.
	assign age      = now_q - rd_stamp;
	assign gust_old = age > {{(STAMP_W-WIN_W){1'b0}}, gust_win_q};
	assign avg_old  = age > {{(STAMP_W-WIN_W){1'b0}}, avg_win_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			avg_win_q   <= AVG_WINDOW_RESET;
			gust_win_q  <= GUST_WINDOW_RESET;
			wp_q        <= '0;
			fill_q      <= '0;
			now_q       <= '0;
			slot_q      <= '0;
			n_q         <= '0;
			gust_open_q <= 1'b0;
			avg_open_q  <= 1'b0;
			rd_s1       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					REG_AVG_WINDOW:  avg_win_q  <= cfg_data[WIN_W-1:0];
					REG_GUST_WINDOW: gust_win_q <= cfg_data[WIN_W-1:0];
					default: ;
				endcase
			end

			rd_s1 <= cmd.issue;

			if (cmd.accept) begin
				n_q         <= '0;
				gust_open_q <= 1'b1;
				avg_open_q  <= 1'b1;
				if (in_command == CMD_SAMPLE) begin
					wp_q   <= wp_next;
					slot_q <= wp_next;
					if (fill_q != FULL_COUNT) begin
						fill_q <= fill_q + 1'b1;
					end
				end else begin
					now_q  <= now_q + 1'b1;
					slot_q <= wp_q;
				end
			end else if (cmd.issue) begin
				slot_q <= prev_slot;
				n_q    <= n_q + 1'b1;
			end

			// A read issued after both windows closed is simply ignored here.
			if (rd_s1) begin
				if (gust_open_q && gust_old) begin
					gust_open_q <= 1'b0;
				end
				if (avg_open_q && avg_old) begin
					avg_open_q <= 1'b0;
				end
			end

			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			gust_q  <= '0;
			sum_q   <= '0;
			count_q <= '0;
		end else if (rd_s1) begin
			if (gust_open_q && !gust_old && (rd_speed > gust_q)) begin
				gust_q <= rd_speed;
			end
			if (avg_open_q && !avg_old) begin
				sum_q   <= sum_q + {{(SUM_W-SPEED_W){1'b0}}, rd_speed};
				count_q <= count_q + 1'b1;
			end
		end

		if (cmd.out_load) begin
			out_gust_q <= gust_q;
			out_avg_q  <= (count_q == '0) ? '0 : quotient;
		end
	end

	wgaa_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (sum_q),
		.divisor  (count_q),
		.busy     (div_busy),
		.quotient (quotient)
	);

	always_comb begin
		stat.walk_done = (n_q == fill_q) || (!gust_open_q && !avg_open_q);
		stat.rd_pend   = rd_s1;
		stat.div_busy  = div_busy;
		stat.out_full  = out_valid_q && !out_ready;
	end

	assign out_valid     = out_valid_q;
	assign gust_speed    = out_gust_q;
	assign average_speed = out_avg_q;

endmodule
